[src/rcl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_pkg
// Shared types and constants of the RAMSETE control law datapath.
// ----------------------------------------------------------------------------
package rcl_pkg;

	localparam int PROD_W = 62;
	localparam logic [60:0] PROD_LIMIT = 61'h1000_0000_0000_0000;

	localparam logic [7:0] REG_BETA   = 8'd0;
	localparam logic [7:0] REG_LAMBDA = 8'd1;

	localparam logic [31:0] ATAN_TAB [24] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               flip;
	} cordic_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_t;

	typedef struct packed {
		logic [31:0] rem;
		logic [31:0] bits;
		logic [31:0] q;
		logic [31:0] d;
	} div_t;

endpackage

[src/rcl_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_cordic_cell
// One rotation-mode CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
module rcl_cordic_cell #(
	parameter int SHIFT = 0
) (
	input  logic            clk,
	input  logic            en,
	input  rcl_pkg::cordic_t din,
	output rcl_pkg::cordic_t dout
);
	import rcl_pkg::*;

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] ang;
	cordic_t nxt;

	assign ang = $signed(ATAN_TAB[SHIFT]);

	always_comb begin
		dx = din.y >>> SHIFT;
		dy = din.x >>> SHIFT;
		nxt.flip = din.flip;
		if (!din.z[31]) begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ang;
		end else begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ang;
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end

endmodule

[src/rcl_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_sqrt_cell
// One result bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module rcl_sqrt_cell (
	input  logic           clk,
	input  logic           en,
	input  rcl_pkg::sqrt_t din,
	output rcl_pkg::sqrt_t dout
);
	import rcl_pkg::*;

	logic [35:0] t;
	logic [35:0] c;
	sqrt_t nxt;

	always_comb begin
		t = {din.rem, din.rad[63:62]};
		c = {2'b00, din.root, 2'b01};
		nxt.rad = {din.rad[61:0], 2'b00};
		if (t >= c) begin
			nxt.rem  = 34'(t - c);
			nxt.root = {din.root[30:0], 1'b1};
		end else begin
			nxt.rem  = t[33:0];
			nxt.root = {din.root[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end

endmodule

[src/rcl_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_div_cell
// One quotient bit of a restoring unsigned divider, registered.
// ----------------------------------------------------------------------------
module rcl_div_cell (
	input  logic          clk,
	input  logic          en,
	input  rcl_pkg::div_t din,
	output rcl_pkg::div_t dout
);
	import rcl_pkg::*;

	logic [32:0] t;
	div_t nxt;

	always_comb begin
		t = {din.rem, din.bits[31]};
		nxt.d    = din.d;
		nxt.bits = {din.bits[30:0], 1'b0};
		if (t >= {1'b0, din.d}) begin
			nxt.rem = 32'(t - {1'b0, din.d});
			nxt.q   = {din.q[30:0], 1'b1};
		end else begin
			nxt.rem = t[31:0];
			nxt.q   = {din.q[30:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) dout <= nxt;
	end

endmodule

[src/rcl_wmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_wmul
// Two-stage signed multiply, magnitude shifted right and clamped to 2^60.
// ----------------------------------------------------------------------------
module rcl_wmul #(
	parameter int AW = 42,
	parameter int BW = 36,
	parameter int SH = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [AW-1:0]              a,
	input  logic signed [BW-1:0]              b,
	output logic signed [rcl_pkg::PROD_W-1:0] p
);
	import rcl_pkg::*;

	logic [AW-1:0] am;
	logic [BW-1:0] bm;
	logic [31+BW:0] pl_s1;
	logic [AW-33+BW:0] ph_s1;
	logic neg_s1;
	logic [AW+BW-1:0] full;
	logic [AW+BW-1:0] shr;
	logic [60:0] mag;

	assign am = a[AW-1] ? AW'(-a) : AW'(a);
	assign bm = b[BW-1] ? BW'(-b) : BW'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1  <= am[31:0] * bm;
			ph_s1  <= am[AW-1:32] * bm;
			neg_s1 <= a[AW-1] ^ b[BW-1];
		end
	end

	always_comb begin
		full = {ph_s1, 32'h0} + (AW+BW)'(pl_s1);
		shr  = full >> SH;
		mag  = (shr > (AW+BW)'(PROD_LIMIT)) ? PROD_LIMIT : 61'(shr);
	end

	always_ff @(posedge clk) begin
		if (en) p <= neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

endmodule

[src/ramsete_control_law_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramsete_control_law_top
// RAMSETE tracking law: CORDIC rows, root and divider rows, product stages.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, stalls only when the output is held.
// Pipeline: the CORDIC cell row, followed by the 32-cell square root and
// divider rows and the wide product stages.
// Reset clears the valid pipeline and loads beta 2.0 and lambda 0.7.
module ramsete_control_law_top #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// rx[31:0] ry[63:32] rh[79:64] gx[111:80] gy[143:112] gh[159:144]
	// speed[191:160] turn_rate[223:192]
	input  logic [223:0] s_axis_tdata,
	// reverse_mode[0]
	input  logic [0:0]   s_axis_tuser,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// speed_command[31:0] turn_command[63:32]
	output logic [63:0]  m_axis_tdata,
	// saturated_flag[0]
	output logic [0:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import rcl_pkg::*;

	localparam int N   = CORDIC_STAGES;
	localparam int LAT = CORDIC_STAGES + 43;
	localparam logic signed [31:0] KINV = 32'sd652032874;
	localparam logic signed [33:0] TWO_PI_Q29 = 34'sd3373259426;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [31:0] v;
		logic signed [31:0] w;
		logic signed [15:0] e;
	} ctx_a_t;

	typedef struct packed {
		logic signed [35:0] ex;
		logic signed [35:0] ey;
		logic signed [20:0] eh;
		logic signed [33:0] vce;
		logic signed [40:0] bv;
		logic signed [31:0] w;
		logic               sneg;
		logic               ezero;
	} ctx_b_t;

	function automatic cordic_t cordic_init(input logic [15:0] ang);
		logic signed [16:0] a;
		cordic_t r;
		a = $signed({ang[15], ang});
		r.flip = 1'b0;
		if (a > 17'sd16384) begin
			a = a - 17'sd32768;
			r.flip = 1'b1;
		end else if (a < -17'sd16384) begin
			a = a + 17'sd32768;
			r.flip = 1'b1;
		end
		r.x = KINV;
		r.y = '0;
		r.z = $signed({a[15:0], 16'h0000});
		return r;
	endfunction

	logic en;
	logic [LAT-1:0] vld_q;
	logic [23:0] beta_q;
	logic [23:0] lambda_q;

	assign en = !vld_q[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q   <= 24'd131072;
			lambda_q <= 24'd45875;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BETA:   beta_q   <= cfg_data;
				REG_LAMBDA: lambda_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: unpack, errors, CORDIC seeds
	logic signed [31:0] rx, ry, gx, gy, vin, win;
	logic [15:0] rh, gh, half, hs, ht;
	assign rx  = s_axis_tdata[31:0];
	assign ry  = s_axis_tdata[63:32];
	assign rh  = s_axis_tdata[79:64];
	assign gx  = s_axis_tdata[111:80];
	assign gy  = s_axis_tdata[143:112];
	assign gh  = s_axis_tdata[159:144];
	assign vin = s_axis_tdata[191:160];
	assign win = s_axis_tdata[223:192];
	assign half = s_axis_tuser[0] ? 16'h8000 : 16'h0000;
	assign hs = rh + half;
	assign ht = gh + half;

	ctx_a_t ctx_s1;
	cordic_t cor_h_s1, cor_e_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.dx <= 33'(gx) - 33'(rx);
			ctx_s1.dy <= 33'(gy) - 33'(ry);
			ctx_s1.v  <= vin;
			ctx_s1.w  <= win;
			ctx_s1.e  <= $signed(16'(ht - hs));
			cor_h_s1  <= cordic_init(hs);
			cor_e_s1  <= cordic_init(16'(ht - hs));
		end
	end

	// CORDIC rows
	cordic_t ch_h [N+1];
	cordic_t ch_e [N+1];
	ctx_a_t ca_q [N];
	assign ch_h[0] = cor_h_s1;
	assign ch_e[0] = cor_e_s1;

	for (genvar i = 0; i < N; i++) begin : g_cordic
		rcl_cordic_cell #(.SHIFT(i)) u_h (.clk(clk), .en(en), .din(ch_h[i]), .dout(ch_h[i+1]));
		rcl_cordic_cell #(.SHIFT(i)) u_e (.clk(clk), .en(en), .din(ch_e[i]), .dout(ch_e[i+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ca_q[0] <= ctx_s1;
			for (int i = 1; i < N; i++) ca_q[i] <= ca_q[i-1];
		end
	end

	// stage 2: quadrant fix, squares, heading error scale
	logic signed [31:0] sh_s2, ch_s2, se_s2, ce_s2;
	logic [63:0] mv2_s2, mw2_s2;
	logic signed [49:0] pe_s2;
	logic signed [32:0] dx_s2, dy_s2;
	logic signed [31:0] v_s2, w_s2;
	logic ezero_s2;
	logic [31:0] mv_c, mw_c;
	logic signed [49:0] pe_c;

	assign mv_c = ca_q[N-1].v[31] ? 32'(-ca_q[N-1].v) : 32'(ca_q[N-1].v);
	assign mw_c = ca_q[N-1].w[31] ? 32'(-ca_q[N-1].w) : 32'(ca_q[N-1].w);
	assign pe_c = ca_q[N-1].e * TWO_PI_Q29;

	always_ff @(posedge clk) begin
		if (en) begin
			sh_s2    <= ch_h[N].flip ? -ch_h[N].y : ch_h[N].y;
			ch_s2    <= ch_h[N].flip ? -ch_h[N].x : ch_h[N].x;
			se_s2    <= ch_e[N].flip ? -ch_e[N].y : ch_e[N].y;
			ce_s2    <= ch_e[N].flip ? -ch_e[N].x : ch_e[N].x;
			mv2_s2   <= mv_c * mv_c;
			mw2_s2   <= mw_c * mw_c;
			pe_s2    <= pe_c;
			dx_s2    <= ca_q[N-1].dx;
			dy_s2    <= ca_q[N-1].dy;
			v_s2     <= ca_q[N-1].v;
			w_s2     <= ca_q[N-1].w;
			ezero_s2 <= (ca_q[N-1].e == 16'sd0);
		end
	end

	// stage 3: rotation products, beta products, v*cos(e) product, divider operands
	logic signed [64:0] pxs_s3, pyc_s3, pxc_s3, pys_s3;
	logic [55:0] bl_s3, bh_s3, bvm_s3;
	logic [63:0] mw2_s3, pv_s3;
	logic [31:0] nabs_s3, dabs_s3;
	logic sneg_s3, vneg_s3, ezero_s3, mvb_neg_s3;
	logic signed [20:0] eh_s3;
	logic signed [31:0] w_s3;
	logic signed [34:0] rad_c;
	logic [31:0] mvb_c, mce_c;

	assign rad_c = 35'(pe_s2 >>> 15);
	assign mvb_c = v_s2[31] ? 32'(-v_s2) : 32'(v_s2);
	assign mce_c = ce_s2[31] ? 32'(-ce_s2) : 32'(ce_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			pxs_s3     <= dx_s2 * sh_s2;
			pyc_s3     <= dy_s2 * ch_s2;
			pxc_s3     <= dx_s2 * ch_s2;
			pys_s3     <= dy_s2 * sh_s2;
			bl_s3      <= beta_q * mv2_s2[31:0];
			bh_s3      <= beta_q * mv2_s2[63:32];
			bvm_s3     <= beta_q * mvb_c;
			pv_s3      <= mvb_c * mce_c;
			vneg_s3    <= v_s2[31] ^ ce_s2[31];
			mvb_neg_s3 <= v_s2[31];
			mw2_s3     <= mw2_s2;
			nabs_s3    <= se_s2[31] ? 32'(-se_s2) : 32'(se_s2);
			dabs_s3    <= rad_c[34] ? 32'(-rad_c) : 32'(rad_c);
			sneg_s3    <= se_s2[31] ^ pe_s2[49];
			eh_s3      <= 21'(pe_s2 >>> 29);
			w_s3       <= w_s2;
			ezero_s3   <= ezero_s2;
		end
	end

	// stage 4: rotated errors, beta*v^2 term, v*cos(e) and beta*v terms
	logic signed [35:0] ex_s4, ey_s4;
	logic [63:0] sum1_s4, mw2_s4;
	logic signed [33:0] vce_s4;
	logic signed [40:0] bv_s4;
	logic [31:0] nabs_s4, dabs_s4;
	logic sneg_s4, ezero_s4;
	logic signed [20:0] eh_s4;
	logic signed [31:0] w_s4;
	logic [87:0] full_c;
	logic [71:0] shr_c;
	logic [32:0] vm_c;
	logic [39:0] bm_c;

	assign full_c = {bh_s3, 32'h0} + 88'(bl_s3);
	assign shr_c  = 72'(full_c >> 16);
	assign vm_c   = 33'(pv_s3 >> 30);
	assign bm_c   = 40'(bvm_s3 >> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s4    <= 36'(pxs_s3 >>> 30) + 36'(pyc_s3 >>> 30);
			ey_s4    <= 36'(pxc_s3 >>> 30) - 36'(pys_s3 >>> 30);
			sum1_s4  <= (shr_c[71:64] != 8'h00) ? '1 : shr_c[63:0];
			vce_s4   <= vneg_s3 ? -$signed({1'b0, vm_c}) : $signed({1'b0, vm_c});
			bv_s4    <= mvb_neg_s3 ? -$signed({1'b0, bm_c}) : $signed({1'b0, bm_c});
			mw2_s4   <= mw2_s3;
			nabs_s4  <= nabs_s3;
			dabs_s4  <= dabs_s3;
			sneg_s4  <= sneg_s3;
			ezero_s4 <= ezero_s3;
			eh_s4    <= eh_s3;
			w_s4     <= w_s3;
		end
	end

	// stage 5: radicand with saturation, row seeds
	logic [64:0] rsum_c;
	sqrt_t sq_s5;
	div_t dv_s5;
	ctx_b_t cb_s5;

	assign rsum_c = {1'b0, sum1_s4} + {1'b0, mw2_s4};

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5.rem  <= '0;
			sq_s5.root <= '0;
			sq_s5.rad  <= rsum_c[64] ? '1 : rsum_c[63:0];
			dv_s5.rem  <= {2'b00, nabs_s4[31:2]};
			dv_s5.bits <= {nabs_s4[1:0], 30'h0};
			dv_s5.q    <= '0;
			dv_s5.d    <= dabs_s4;
			cb_s5.ex    <= ex_s4;
			cb_s5.ey    <= ey_s4;
			cb_s5.eh    <= eh_s4;
			cb_s5.vce   <= vce_s4;
			cb_s5.bv    <= bv_s4;
			cb_s5.w     <= w_s4;
			cb_s5.sneg  <= sneg_s4;
			cb_s5.ezero <= ezero_s4;
		end
	end

	// square root and divider rows
	sqrt_t sq [33];
	div_t dv [33];
	ctx_b_t cb_q [32];
	assign sq[0] = sq_s5;
	assign dv[0] = dv_s5;

	for (genvar j = 0; j < 32; j++) begin : g_rows
		rcl_sqrt_cell u_sq (.clk(clk), .en(en), .din(sq[j]), .dout(sq[j+1]));
		rcl_div_cell  u_dv (.clk(clk), .en(en), .din(dv[j]), .dout(dv[j+1]));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cb_q[0] <= cb_s5;
			for (int i = 1; i < 32; i++) cb_q[i] <= cb_q[i-1];
		end
	end

	// stage 6: gain k and sinc
	logic signed [41:0] k_s6;
	logic signed [32:0] sinc_s6;
	logic signed [35:0] ex_s6, ey_s6;
	logic signed [20:0] eh_s6;
	logic signed [33:0] vce_s6;
	logic signed [40:0] bv_s6;
	logic signed [31:0] w_s6;
	logic [55:0] kp_c;

	assign kp_c = lambda_q * sq[32].root;

	always_ff @(posedge clk) begin
		if (en) begin
			k_s6 <= $signed({1'b0, 41'(kp_c >> 15)});
			if (cb_q[31].ezero) sinc_s6 <= 33'sd1073741824;
			else if (cb_q[31].sneg) sinc_s6 <= -$signed({1'b0, dv[32].q});
			else sinc_s6 <= $signed({1'b0, dv[32].q});
			ex_s6  <= cb_q[31].ex;
			ey_s6  <= cb_q[31].ey;
			eh_s6  <= cb_q[31].eh;
			vce_s6 <= cb_q[31].vce;
			bv_s6  <= cb_q[31].bv;
			w_s6   <= cb_q[31].w;
		end
	end

	// product stages
	logic signed [PROD_W-1:0] kex, keh, bvs, bsey;
	logic signed [35:0] ey_s7, ey_s8;
	logic signed [33:0] vce_s7, vce_s8, vce_s9, vce_s10;
	logic signed [31:0] w_s7, w_s8, w_s9, w_s10;
	logic signed [PROD_W-1:0] kex_s9, kex_s10, keh_s9, keh_s10;

	rcl_wmul #(.AW(42), .BW(36), .SH(16)) u_kex (
		.clk(clk), .en(en), .a(k_s6), .b(ex_s6), .p(kex));
	rcl_wmul #(.AW(42), .BW(21), .SH(16)) u_keh (
		.clk(clk), .en(en), .a(k_s6), .b(eh_s6), .p(keh));
	rcl_wmul #(.AW(41), .BW(33), .SH(30)) u_bvs (
		.clk(clk), .en(en), .a(bv_s6), .b(sinc_s6), .p(bvs));
	rcl_wmul #(.AW(PROD_W), .BW(36), .SH(16)) u_bsey (
		.clk(clk), .en(en), .a(bvs), .b(ey_s8), .p(bsey));

	always_ff @(posedge clk) begin
		if (en) begin
			ey_s7   <= ey_s6;
			ey_s8   <= ey_s7;
			vce_s7  <= vce_s6;
			vce_s8  <= vce_s7;
			vce_s9  <= vce_s8;
			vce_s10 <= vce_s9;
			w_s7    <= w_s6;
			w_s8    <= w_s7;
			w_s9    <= w_s8;
			w_s10   <= w_s9;
			kex_s9  <= kex;
			kex_s10 <= kex_s9;
			keh_s9  <= keh;
			keh_s10 <= keh_s9;
		end
	end

	// output stage: sums and saturation
	logic signed [62:0] speed_c;
	logic signed [63:0] turn_c;
	logic [31:0] speed_q, turn_q;
	logic flag_q;
	logic sat_sp, sat_tn;

	assign speed_c = 63'(vce_s10) + 63'(kex_s10);
	assign turn_c  = 64'(w_s10) + 64'(keh_s10) + 64'(bsey);
	assign sat_sp  = (speed_c > 63'sd2147483647) || (speed_c < -63'sd2147483648);
	assign sat_tn  = (turn_c > 64'sd2147483647) || (turn_c < -64'sd2147483648);

	always_ff @(posedge clk) begin
		if (en) begin
			if (speed_c > 63'sd2147483647) speed_q <= 32'h7FFF_FFFF;
			else if (speed_c < -63'sd2147483648) speed_q <= 32'h8000_0000;
			else speed_q <= speed_c[31:0];
			if (turn_c > 64'sd2147483647) turn_q <= 32'h7FFF_FFFF;
			else if (turn_c < -64'sd2147483648) turn_q <= 32'h8000_0000;
			else turn_q <= turn_c[31:0];
			flag_q <= sat_sp || sat_tn;
		end
	end

	assign m_axis_tvalid   = vld_q[LAT-1];
	assign m_axis_tdata    = {turn_q, speed_q};
	assign m_axis_tuser[0] = flag_q;

endmodule

[src/rcl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcl_checker
// Port-level checks on the RAMSETE control law block, bound to the top.
// ----------------------------------------------------------------------------
module rcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result request changed");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output stall");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000 ||
		m_axis_tdata[63:32] == 32'h7FFF_FFFF || m_axis_tdata[63:32] == 32'h8000_0000)
		else $error("saturation flag without a clipped command");

endmodule

bind ramsete_control_law_top rcl_checker u_rcl_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready)
);

[verif/ramsete_control_law_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ramsete_control_law_top_test
// Streams pose samples through the tracking law and checks each command pair
// against an in-bench fixed-point model, under random idling, a long output
// hold-off, a drain pause and several gain settings.
// ----------------------------------------------------------------------------
module ramsete_control_law_top_test;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 43;
	localparam logic [7:0] REG_BETA = rcl_pkg::REG_BETA;
	localparam logic [7:0] REG_LAMBDA = rcl_pkg::REG_LAMBDA;
	localparam logic [7:0] REG_BAD = 8'd7;
	localparam logic [63:0] PLIM = 64'h1000_0000_0000_0000;
	localparam longint TWO_PI_Q29 = 64'd3373259426;
	localparam longint KINV = 652032874;

	typedef struct {
		logic [223:0] data;
		logic         rev;
	} pose_t;

	typedef struct {
		logic [31:0] speed;
		logic [31:0] turn;
		logic        sat;
	} cmd_t;

	logic         clk;
	logic         arst_n;
	logic [223:0] s_axis_tdata;
	logic [0:0]   s_axis_tuser;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [0:0]   m_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_index;
	logic [23:0]  cfg_data;

	pose_t  pose_q[$];
	cmd_t   cmd_q[$];
	int     errors;
	logic   [63:0] beta, lambda;
	logic   feed_on, rx_idle_on, tx_idle_on;
	int     hold_cycles;
	logic   s_axis_tready_q;

	ramsete_control_law_top #(.CORDIC_STAGES(STAGES)) dut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic [63:0] umul_shr(logic [63:0] a, logic [63:0] b, int s,
			logic [63:0] lim);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		if (p[127:64] != 0 || p[63:0] > lim) return lim;
		return p[63:0];
	endfunction

	function automatic longint smul_shr(longint a, longint b, int s);
		logic [63:0] ma, mb, r;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		r = umul_shr(ma, mb, s, PLIM);
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [63:0] isqrt(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic void sincos(input logic [15:0] ang, output longint sn,
			output longint cs);
		longint a, x, y, z, dx, dy;
		logic flip;
		a = ang;
		flip = 0;
		x = KINV;
		y = 0;
		if (a >= 32768) a -= 65536;
		if (a > 16384) begin
			a -= 32768; flip = 1;
		end else if (a < -16384) begin
			a += 32768; flip = 1;
		end
		z = a * 65536;
		for (int i = 0; i < STAGES && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(rcl_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(rcl_pkg::ATAN_TAB[i]);
			end
		end
		sn = flip ? -y : y;
		cs = flip ? -x : x;
	endfunction

	function automatic longint sat32(longint v, ref logic flag);
		if (v > 64'sd2147483647) begin
			flag = 1; return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1; return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic cmd_t control_law(pose_t p);
		longint rx, ry, gx, gy, v, w, e, dx, dy, sh, ch, se, ce, ex, ey, eh, sinc, k;
		longint speed, turn;
		logic [15:0] half, hs, ht;
		logic [63:0] mv, mw, radic, root, mw2;
		logic flag;
		cmd_t c;
		rx = signed'(p.data[31:0]);
		ry = signed'(p.data[63:32]);
		gx = signed'(p.data[111:80]);
		gy = signed'(p.data[143:112]);
		v = signed'(p.data[191:160]);
		w = signed'(p.data[223:192]);
		half = p.rev ? 16'h8000 : 16'h0;
		hs = p.data[79:64] + half;
		ht = p.data[159:144] + half;
		e = signed'(16'(ht - hs));
		dx = gx - rx;
		dy = gy - ry;
		flag = 0;
		sincos(hs, sh, ch);
		sincos(16'(e), se, ce);
		ex = floor_shr(dx * sh, 30) + floor_shr(dy * ch, 30);
		ey = floor_shr(dx * ch, 30) - floor_shr(dy * sh, 30);
		eh = floor_shr(e * TWO_PI_Q29, 29);
		if (e == 0) sinc = 64'sd1 << 30;
		else sinc = (se * (64'sd1 << 30)) / floor_shr(e * TWO_PI_Q29, 15);
		mv = v < 0 ? -v : v;
		mw = w < 0 ? -w : w;
		mw2 = mw * mw;
		radic = umul_shr(beta, mv * mv, 16, '1);
		if (radic > ~mw2) radic = '1;
		else radic += mw2;
		root = isqrt(radic);
		k = longint'((2 * lambda * root) >> 16);
		speed = smul_shr(v, ce, 30) + smul_shr(k, ex, 16);
		turn = w + smul_shr(k, eh, 16) +
			smul_shr(smul_shr(smul_shr(longint'(beta), v, 16), sinc, 30), ey, 16);
		speed = sat32(speed, flag);
		turn = sat32(turn, flag);
		c.speed = speed[31:0];
		c.turn = turn[31:0];
		c.sat = flag;
		return c;
	endfunction

	function automatic logic [31:0] rand_q(int mode);
		case (mode)
			0: return $urandom;
			1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			2: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
			default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		endcase
	endfunction

	task automatic add_pose(logic [31:0] rx, ry, gx, gy, v, w, logic [15:0] rh, gh,
			logic rev);
		pose_t p;
		p.data = {w, v, gh, gy, gx, rh, ry, rx};
		p.rev = rev;
		pose_q.push_back(p);
	endtask

	task automatic add_random(int n);
		int m;
		for (int i = 0; i < n; i++) begin
			m = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 2) == 0 ? 0 : 2);
			if ($urandom_range(0, 19) == 0) m = 3;
			add_pose(rand_q(m), rand_q(m), rand_q(m), rand_q(m), rand_q(m), rand_q(m),
				16'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	task automatic wait_drain;
		while (pose_q.size() != 0 || cmd_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(logic [7:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_BETA) beta = val;
		else if (idx == REG_LAMBDA) lambda = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready_q) begin
				if (feed_on && pose_q.size() != 0
						&& !(tx_idle_on && $urandom_range(0, 99) < 23)) begin
					s_axis_tdata <= pose_q[0].data;
					s_axis_tuser <= pose_q[0].rev;
					s_axis_tvalid <= 1;
					cmd_q.push_back(control_law(pose_q.pop_front()));
				end else begin
					s_axis_tvalid <= 0;
				end
			end
		end
	end

	always @(posedge clk) s_axis_tready_q <= s_axis_tvalid && s_axis_tready;

	// result monitor and receiver idling
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			if (cmd_q.size() == 0) begin
				$display("%0t unexpected result %h", $realtime, m_axis_tdata);
				errors++;
			end else begin
				if ({m_axis_tuser, m_axis_tdata} !=
						{cmd_q[0].sat, cmd_q[0].turn, cmd_q[0].speed}) begin
					$display("%0t mismatch expected sat %b turn %h speed %h actual sat %b turn %h speed %h",
						$realtime, cmd_q[0].sat, cmd_q[0].turn, cmd_q[0].speed,
						m_axis_tuser, m_axis_tdata[63:32], m_axis_tdata[31:0]);
					errors++;
				end
				void'(cmd_q.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 0;
		end else begin
			m_axis_tready <= !(rx_idle_on && $urandom_range(0, 99) < 23);
		end
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		errors = 0;
		beta = 131072;
		lambda = 45875;
		feed_on = 0;
		rx_idle_on = 1;
		tx_idle_on = 1;
		hold_cycles = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: zero error, half-turn error, extremes, reverse
		add_pose(0, 0, 0, 0, 0, 0, 16'h0, 16'h0, 1'b0);
		add_pose(0, 0, 32'h10000, 0, 32'h10000, 0, 16'h0, 16'h0, 1'b0);
		add_pose(0, 0, 0, 0, 32'h10000, 32'h8000, 16'h0, 16'h8000, 1'b0);
		add_pose(0, 0, 0, 0, 32'h10000, 32'h8000, 16'h8000, 16'h0, 1'b1);
		add_pose(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'h0, 1'b0);
		add_pose(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 16'h0, 16'hffff, 1'b1);
		add_pose('1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
		add_pose(32'h1234, 32'h5678, 32'h20000, 32'h30000, 32'h8000, 32'h4000,
			16'h4000, 16'h4001, 1'b0);
		add_pose(0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 16'hc000, 16'h3fff,
			1'b1);
		add_pose(0, 0, 0, 0, 32'h10000, 0, 16'h1, 16'h0, 1'b0);
		add_pose(0, 0, 0, 0, 32'hffff0000, 0, 16'h0, 16'h1, 1'b0);
		feed_on = 1;
		wait_drain();

		write_reg(REG_BETA, 24'hffffff);
		write_reg(REG_LAMBDA, 24'hffffff);
		write_reg(REG_BAD, 24'h123456);
		add_random(150);
		wait_drain();

		write_reg(REG_BETA, 24'h0);
		write_reg(REG_LAMBDA, 24'h0);
		add_random(150);
		wait_drain();

		write_reg(REG_BETA, 24'($urandom));
		write_reg(REG_LAMBDA, 24'($urandom));
		rx_idle_on = 0;
		tx_idle_on = 0;
		add_random(400);
		@(negedge clk);
		hold_cycles = 300;
		wait_drain();
		rx_idle_on = 1;
		tx_idle_on = 1;

		write_reg(REG_BETA, 24'd131072);
		write_reg(REG_LAMBDA, 24'd45875);
		add_random(500);
		wait_drain();

		write_reg(REG_BETA, 24'($urandom));
		write_reg(REG_LAMBDA, 24'($urandom_range(0, 24'h30000)));
		add_random(550);
		wait_drain();

		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
